[sv/asgr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and colour lookup functions for the SGR colour parser.
// Has no dependencies; every other file of the block refers to it by scoped names.
package asgr_pkg;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_VERSION = 3'd1,
        PH_BIT8    = 3'd2,
        PH_R       = 3'd3,
        PH_G       = 3'd4,
        PH_B       = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CURRENT   = 3'd0,
        KIND_DEFAULT   = 3'd1,
        KIND_FRONT     = 3'd2,
        KIND_BACK      = 3'd3,
        KIND_DEF_FRONT = 3'd4,
        KIND_DEF_BACK  = 3'd5,
        KIND_UNKNOWN   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK_CONT   = 2'd0,
        ST_OK_BREAK  = 2'd1,
        ST_ERR_CONT  = 2'd2,
        ST_ERR_BREAK = 2'd3
    } status_t;

    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_M       = 8'h6D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [8:0] ACC_SAT      = 9'd256;
    localparam logic [8:0] ACC_MAX      = 9'd255;
    localparam logic [7:0] GREY_BASE    = 8'd232;
    localparam logic [7:0] CUBE_BASE    = 8'd16;
    localparam logic [7:0] CUBE_SIDE_SQ = 8'd36;
    localparam logic [7:0] CUBE_SIDE    = 8'd6;

    typedef struct packed {
        phase_t       phase;
        logic [8:0]   acc;
        logic         has_digit;
        logic         not_number;
        kind_t        kind;
        logic [23:0]  colour;
        logic         tc_valid;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:      PH_FIRST,
        acc:        9'd0,
        has_digit:  1'b0,
        not_number: 1'b0,
        kind:       KIND_CURRENT,
        colour:     24'd0,
        tc_valid:   1'b1
    };

    typedef struct packed {
        logic         field_done;
        status_t      status;
        kind_t        kind;
        logic [23:0]  colour;
    } result_t;

    function automatic logic [23:0] palette16(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h010101;
            4'd1:    rgb = 24'hDE382B;
            4'd2:    rgb = 24'h39B54A;
            4'd3:    rgb = 24'hFFC706;
            4'd4:    rgb = 24'h006FB8;
            4'd5:    rgb = 24'h762671;
            4'd6:    rgb = 24'h2CB5E9;
            4'd7:    rgb = 24'hCCCCCC;
            4'd8:    rgb = 24'h808080;
            4'd9:    rgb = 24'hFF0000;
            4'd10:   rgb = 24'h00FF00;
            4'd11:   rgb = 24'hFFFF00;
            4'd12:   rgb = 24'h0000FF;
            4'd13:   rgb = 24'hFF00FF;
            4'd14:   rgb = 24'h00FFFF;
            4'd15:   rgb = 24'hFFFFFF;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] digit);
        logic [7:0] level;
        case (digit)
            3'd0:    level = 8'd0;
            3'd1:    level = 8'd95;
            3'd2:    level = 8'd135;
            3'd3:    level = 8'd175;
            3'd4:    level = 8'd215;
            3'd5:    level = 8'd255;
            default: level = 8'd0;
        endcase
        return level;
    endfunction

    // Returns the base-six digit of a value below six times the step, found
    // with five parallel comparisons.
    function automatic logic [2:0] six_digit(input logic [7:0] value, input logic [7:0] step);
        logic [2:0] digit;
        digit = 3'd0;
        for (int i = 1; i < 6; i++)
        begin
            if (value >= 8'(i) * step)
            begin
                digit = 3'(i);
            end
        end
        return digit;
    endfunction

    function automatic logic [23:0] cube_colour(input logic [7:0] idx);
        logic [7:0] c;
        logic [7:0] rem;
        logic [7:0] low;
        logic [2:0] dr;
        logic [2:0] dg;
        c   = idx - CUBE_BASE;
        dr  = six_digit(c, CUBE_SIDE_SQ);
        rem = c - {5'd0, dr} * CUBE_SIDE_SQ;
        dg  = six_digit(rem, CUBE_SIDE);
        low = rem - {5'd0, dg} * CUBE_SIDE;
        return {cube_level(dr), cube_level(dg), cube_level(low[2:0])};
    endfunction

    function automatic logic [23:0] grey_colour(input logic [7:0] idx);
        logic [7:0] g;
        g = (idx - GREY_BASE) * 8'd10 + 8'd8;
        return {g, g, g};
    endfunction

endpackage

[sv/asgr_step.sv]
`timescale 1ns / 1ps
// Combinational per-byte step: next parser state and the result for one byte.
// Depends on asgr_pkg for the state and result types and the colour functions.
module asgr_step
(
    input  logic [7:0]             char_code,
    input  asgr_pkg::parse_state_t cur,
    output asgr_pkg::parse_state_t nxt,
    output asgr_pkg::result_t      res
);

    logic              is_delim;
    logic              is_digit;
    logic              empty;
    logic              tc_next;
    asgr_pkg::status_t fv_status;
    asgr_pkg::status_t st;
    asgr_pkg::phase_t  adv_phase;
    logic [7:0]        v;
    logic [11:0]       acc_sum;
    logic [7:0]        digit;

    assign is_delim = (char_code == asgr_pkg::CHAR_SEMI) || (char_code == asgr_pkg::CHAR_COLON)
                   || (char_code == asgr_pkg::CHAR_M);
    assign is_digit = (char_code >= asgr_pkg::CHAR_ZERO) && (char_code <= asgr_pkg::CHAR_NINE);
    assign empty    = !cur.has_digit && !cur.not_number;
    assign v        = cur.acc[7:0];
    assign digit    = char_code - asgr_pkg::CHAR_ZERO;
    assign acc_sum  = {3'd0, cur.acc} * 12'd10 + {4'd0, digit};
    assign tc_next  = empty ? 1'b0 : cur.tc_valid;

    always_comb
    begin
        if (cur.not_number)
        begin
            fv_status = asgr_pkg::ST_ERR_BREAK;
        end
        else if (cur.acc > asgr_pkg::ACC_MAX)
        begin
            fv_status = asgr_pkg::ST_ERR_CONT;
        end
        else
        begin
            fv_status = asgr_pkg::ST_OK_CONT;
        end
    end

    always_comb
    begin
        case (cur.phase)
            asgr_pkg::PH_R: adv_phase = asgr_pkg::PH_G;
            asgr_pkg::PH_G: adv_phase = asgr_pkg::PH_B;
            default:        adv_phase = asgr_pkg::PH_FIRST;
        endcase
    end

    always_comb
    begin
        nxt = cur;
        st  = asgr_pkg::ST_OK_CONT;
        if (is_delim)
        begin
            case (cur.phase)
                asgr_pkg::PH_FIRST:
                begin
                    if (empty)
                    begin
                        nxt.kind = asgr_pkg::KIND_DEFAULT;
                        st       = asgr_pkg::ST_OK_BREAK;
                    end
                    else if (fv_status != asgr_pkg::ST_OK_CONT)
                    begin
                        st = fv_status;
                    end
                    else
                    begin
                        nxt.tc_valid = 1'b1;
                        nxt.colour   = 24'd0;
                        st           = asgr_pkg::ST_OK_BREAK;
                        if (v == 8'd0)
                        begin
                            nxt.kind = asgr_pkg::KIND_DEFAULT;
                        end
                        else if (v >= 8'd30 && v <= 8'd37)
                        begin
                            nxt.kind   = asgr_pkg::KIND_FRONT;
                            nxt.colour = asgr_pkg::palette16({1'b0, 3'(v - 8'd30)});
                        end
                        else if (v == 8'd38)
                        begin
                            nxt.kind  = asgr_pkg::KIND_FRONT;
                            nxt.phase = asgr_pkg::PH_VERSION;
                            st        = asgr_pkg::ST_OK_CONT;
                        end
                        else if (v == 8'd39)
                        begin
                            nxt.kind = asgr_pkg::KIND_DEF_FRONT;
                        end
                        else if (v >= 8'd40 && v <= 8'd47)
                        begin
                            nxt.kind   = asgr_pkg::KIND_BACK;
                            nxt.colour = asgr_pkg::palette16({1'b0, 3'(v - 8'd40)});
                        end
                        else if (v == 8'd48)
                        begin
                            nxt.kind  = asgr_pkg::KIND_BACK;
                            nxt.phase = asgr_pkg::PH_VERSION;
                            st        = asgr_pkg::ST_OK_CONT;
                        end
                        else if (v == 8'd49)
                        begin
                            nxt.kind = asgr_pkg::KIND_DEF_BACK;
                        end
                        else if (v >= 8'd90 && v <= 8'd97)
                        begin
                            nxt.kind   = asgr_pkg::KIND_FRONT;
                            nxt.colour = asgr_pkg::palette16({1'b1, 3'(v - 8'd90)});
                        end
                        else if (v >= 8'd100 && v <= 8'd107)
                        begin
                            nxt.kind   = asgr_pkg::KIND_BACK;
                            nxt.colour = asgr_pkg::palette16({1'b1, 3'(v - 8'd100)});
                        end
                        else
                        begin
                            nxt.kind = asgr_pkg::KIND_UNKNOWN;
                            st       = asgr_pkg::ST_ERR_CONT;
                        end
                    end
                end
                asgr_pkg::PH_VERSION:
                begin
                    if (empty)
                    begin
                        nxt.phase = asgr_pkg::PH_FIRST;
                        st        = asgr_pkg::ST_ERR_CONT;
                    end
                    else if (fv_status != asgr_pkg::ST_OK_CONT)
                    begin
                        st = fv_status;
                    end
                    else if (v == 8'd5)
                    begin
                        nxt.phase = asgr_pkg::PH_BIT8;
                    end
                    else if (v == 8'd2)
                    begin
                        nxt.phase = asgr_pkg::PH_R;
                    end
                    else
                    begin
                        st = asgr_pkg::ST_ERR_CONT;
                    end
                end
                asgr_pkg::PH_BIT8:
                begin
                    if (empty)
                    begin
                        nxt.phase = asgr_pkg::PH_FIRST;
                        st        = asgr_pkg::ST_ERR_CONT;
                    end
                    else if (fv_status != asgr_pkg::ST_OK_CONT)
                    begin
                        st = fv_status;
                    end
                    else
                    begin
                        if (v <= 8'd15)
                        begin
                            nxt.colour   = asgr_pkg::palette16(v[3:0]);
                            nxt.tc_valid = 1'b1;
                        end
                        else if (v >= asgr_pkg::GREY_BASE)
                        begin
                            nxt.colour = asgr_pkg::grey_colour(v);
                        end
                        else
                        begin
                            nxt.colour = asgr_pkg::cube_colour(v);
                        end
                        nxt.phase = asgr_pkg::PH_FIRST;
                        st        = asgr_pkg::ST_OK_BREAK;
                    end
                end
                asgr_pkg::PH_R, asgr_pkg::PH_G, asgr_pkg::PH_B:
                begin
                    nxt.tc_valid = tc_next;
                    nxt.phase    = adv_phase;
                    if (!tc_next)
                    begin
                        nxt.phase = asgr_pkg::PH_FIRST;
                        st        = asgr_pkg::ST_ERR_CONT;
                    end
                    else if (fv_status != asgr_pkg::ST_OK_CONT)
                    begin
                        st = fv_status;
                    end
                    else
                    begin
                        case (cur.phase)
                            asgr_pkg::PH_R: nxt.colour[23:16] = v;
                            asgr_pkg::PH_G: nxt.colour[15:8]  = v;
                            default:        nxt.colour[7:0]   = v;
                        endcase
                        st = (adv_phase == asgr_pkg::PH_FIRST) ? asgr_pkg::ST_OK_BREAK
                                                               : asgr_pkg::ST_OK_CONT;
                    end
                end
                default:
                begin
                    st = asgr_pkg::ST_OK_CONT;
                end
            endcase
            nxt.acc        = 9'd0;
            nxt.has_digit  = 1'b0;
            nxt.not_number = 1'b0;
        end
        else if (is_digit)
        begin
            nxt.acc       = (acc_sum > 12'd255) ? asgr_pkg::ACC_SAT : acc_sum[8:0];
            nxt.has_digit = 1'b1;
        end
        else
        begin
            nxt.not_number = 1'b1;
        end
    end

    assign res.field_done = is_delim;
    assign res.status     = st;
    assign res.kind       = nxt.kind;
    assign res.colour     = nxt.colour;

endmodule

[sv/asgr_out_buf.sv]
`timescale 1ns / 1ps
// Two-entry result buffer that keeps the parser running while the output is stalled.
// Depends on asgr_pkg for the result type.
module asgr_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  asgr_pkg::result_t push_data,
    output logic              ready,
    output logic              result_valid,
    input  logic              result_stall,
    output asgr_pkg::result_t pop_data
);

    asgr_pkg::result_t mem_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;

    assign ready        = (count_reg != 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && !result_stall;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/ansi_sgr_color_parser_core.sv]
`timescale 1ns / 1ps
// Top level of the SGR colour parser: input register, parser state and result buffer.
// Depends on asgr_pkg, asgr_step and asgr_out_buf.
//
// The parser takes one parameter byte of an SGR escape sequence per clock cycle while
// char_stall is low and returns exactly one result transaction for every byte, in
// order. A byte is held in an input register, the next parser state and result are
// formed by shallow combinational logic, and the result enters a two-entry output
// buffer when the buffer has room, so a result is offered on the output once its byte
// has passed the input register and been written into the buffer. The sustained rate
// is one byte per cycle while the output keeps up; char_stall rises only when both
// buffer entries hold results that the output side has not yet taken.
module ansi_sgr_color_parser_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_code,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       field_done,
    output logic [1:0] status,
    output logic [2:0] result_kind,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [7:0]             char_reg;
    logic                   buf_ready;
    logic                   s1_fire;
    asgr_pkg::parse_state_t state_reg;
    asgr_pkg::parse_state_t state_next;
    asgr_pkg::result_t      step_res;
    asgr_pkg::result_t      out_res;

    assign char_stall    = s1_valid_reg && !buf_ready;
    assign s1_fire       = s1_valid_reg && buf_ready;
    assign s1_valid_next = char_stall ? 1'b1 : char_valid;

    asgr_step u_step
    (
        .char_code (char_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    asgr_out_buf u_out_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s1_fire),
        .push_data    (step_res),
        .ready        (buf_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pop_data     (out_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= asgr_pkg::STATE_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_reg <= char_code;
        end
    end

    assign field_done  = out_res.field_done;
    assign status      = out_res.status;
    assign result_kind = out_res.kind;
    assign red         = out_res.colour[23:16];
    assign green       = out_res.colour[15:8];
    assign blue        = out_res.colour[7:0];

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid)
        else $error("Input stalled while no result is waiting.");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.acc <= asgr_pkg::ACC_SAT)
        else $error("Digit accumulator beyond its saturation value.");

    a_delim_clears_field: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && step_res.field_done) |=>
            (state_reg.acc == 9'd0) && !state_reg.has_digit && !state_reg.not_number)
        else $error("Field not cleared after a delimiter.");

    a_tc_invalid_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.tc_valid |-> (state_reg.phase == asgr_pkg::PH_FIRST))
        else $error("Truecolour marked invalid outside the first-parameter phase.");

endmodule
